### src/obgm_pkg.sv
// ----------------------------------------------------------------------------
// obgm_pkg
// Shared types and constants for the odd-byte group mask encoder.
// ----------------------------------------------------------------------------
package obgm_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [0:0]
    {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

### src/odd_byte_group_mask_encoder.sv
// ----------------------------------------------------------------------------
// odd_byte_group_mask_encoder
// A byte that closes a group shows its mask byte in the cycle after the
// transfer; the group's bytes follow one per cycle while the output is taken.
// Input: one byte per cycle inside a group; a closing byte holds off the input
// while the sequencer drains the group store.
// Reset: state idle, output empty, position 0, mask 1; store contents undefined.
// ----------------------------------------------------------------------------
module odd_byte_group_mask_encoder
    import obgm_pkg::*;
#(
    parameter int GROUP_LEN = 7
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // end_of_message

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] code_byte
    output logic [0:0]        m_axis_tuser,   // [0] group_end
    output logic              m_axis_tlast    // message_end
);

    localparam int IDX_W = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(GROUP_LEN - 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   mask_reg, mask_next;
    logic [IDX_W-1:0]    rd_reg, rd_next;
    logic [IDX_W-1:0]    last_idx_reg, last_idx_next;
    logic                msg_reg, msg_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_data_reg, out_data_next;
    logic                out_gend_reg, out_gend_next;
    logic                out_mend_reg, out_mend_next;
    logic [BYTE_W-1:0]   store [GROUP_LEN];

    logic                in_xfer;
    logic                out_xfer;
    logic                close;
    logic [BYTE_W-1:0]   enc_byte;
    logic [BYTE_W-1:0]   mask_upd;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;

    // odd bytes already have bit 0 set; even bytes plus one is the same thing
    assign enc_byte = s_axis_tdata | BYTE_W'(1);
    assign mask_upd = s_axis_tdata[0]
                    ? (mask_reg | (BYTE_W'(2) << pos_reg)) : mask_reg;
    assign close    = s_axis_tlast || (pos_reg >= POS_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && close)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer && out_gend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        mask_next      = mask_reg;
        rd_next        = rd_reg;
        last_idx_next  = last_idx_reg;
        msg_next       = msg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_gend_next  = out_gend_reg;
        out_mend_next  = out_mend_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (close)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = mask_upd;
                        out_gend_next  = 1'b0;
                        out_mend_next  = 1'b0;
                        last_idx_next  = pos_reg;
                        msg_next       = s_axis_tlast;
                        rd_next        = '0;
                        pos_next       = '0;
                        mask_next      = BYTE_W'(1);
                    end
                    else
                    begin
                        pos_next  = pos_reg + IDX_W'(1);
                        mask_next = mask_upd;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_xfer && !out_gend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = store[rd_reg];
                    out_gend_next  = (rd_reg == last_idx_reg);
                    out_mend_next  = (rd_reg == last_idx_reg) && msg_reg;
                    rd_next        = rd_reg + IDX_W'(1);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            mask_reg      <= BYTE_W'(1);
            rd_reg        <= '0;
            last_idx_reg  <= '0;
            msg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            mask_reg      <= mask_next;
            rd_reg        <= rd_next;
            last_idx_reg  <= last_idx_next;
            msg_reg       <= msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_gend_reg <= out_gend_next;
        out_mend_reg <= out_mend_next;
        if (in_xfer)
        begin
            store[pos_reg] <= enc_byte;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_gend_reg;
    assign m_axis_tlast    = out_mend_reg;

    a_no_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != '0))
        else $error("zero code byte on output");

    a_mask_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && close) |=> (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tlast))
        else $error("mask byte not presented after group close");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !out_gend_reg) |-> (rd_reg <= last_idx_reg))
        else $error("group read index past end of group");

    a_mend_has_gend: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("message end without group end");

    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_xfer && out_gend_reg) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after final byte");

endmodule
